[rtl/fifo_reader_writer_admission_macros.svh]
// Assertion macros used by the lock datapath module.
`ifndef FIFO_READER_WRITER_ADMISSION_MACROS_SVH
`define FIFO_READER_WRITER_ADMISSION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error(msg);

`endif

[rtl/frwa_pkg.sv]
package frwa_pkg;

	// Sizes of the wait queue, the ids and the reader counter.
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_BITS     = 8;
	localparam int MAX_READERS = 255;
	localparam int RC_W        = 8;
	localparam int ENTRY_W     = ID_BITS + 1;

	// Command and mode codes of an input word.
	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;
	localparam logic MODE_READ   = 1'b0;
	localparam logic MODE_WRITE  = 1'b1;

	// Event codes of a result word.
	typedef enum logic [2:0] {
		EV_GRANT  = 3'd0,
		EV_QUEUED = 3'd1,
		EV_NONE   = 3'd2,
		EV_FULL   = 3'd3,
		EV_RELERR = 3'd4
	} event_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic acquire;
		logic error;
		logic release_op;
		logic grant;
		logic none;
		logic last;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_release;
		logic rel_bad;
		logic head_ok;
		logic next_ok;
	} stat_t;

	// A request is admissible when no writer holds the object and, for a read,
	// the reader count is below its limit, or, for a write, no reader is active.
	function automatic logic can_admit(input logic mode, input logic writer,
			input logic [RC_W-1:0] readers);
		logic ok;
		if (writer) begin
			ok = 1'b0;
		end else if (mode == MODE_READ) begin
			ok = readers < RC_W'(MAX_READERS);
		end else begin
			ok = readers == '0;
		end
		return ok;
	endfunction

endpackage

[rtl/fifo_reader_writer_admission.sv]
// Channel  | Signals                                           | Handshake
// ---------+---------------------------------------------------+---------------------------
// request  | command, access_mode, requester_id                | start high while busy low
// result   | event_res, grant_id, grant_mode, writer_holder,   | strobe high for one cycle
//          | writer_on, reader_count, lock_idle, last          |
//
// An acquire or a bad release gives a single result, computed in ST_EXEC from the
// captured request and registered. A good release drops its holder in ST_EXEC, then
// ST_SCAN grants queued entries from the front, one per cycle, or reports none if none
// is granted. busy stays high until the final result (marked by last) is registered.
// Reset clears the counters, pointers and writer state; queue entries are never read
// before they are written. The result side has no stall.
module fifo_reader_writer_admission (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           command,
	input  logic                           access_mode,
	input  logic [frwa_pkg::ID_BITS-1:0]   requester_id,
	output logic                           strobe,
	output logic [2:0]                     event_res,
	output logic [frwa_pkg::ID_BITS-1:0]   grant_id,
	output logic                           grant_mode,
	output logic [frwa_pkg::ID_BITS-1:0]   writer_holder,
	output logic                           writer_on,
	output logic [frwa_pkg::RC_W-1:0]      reader_count,
	output logic                           lock_idle,
	output logic                           last
);

	frwa_pkg::ctrl_t ctrl;
	frwa_pkg::stat_t stat;

	// Sequencer for the acquire, release and grant steps.
	frwa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Lock state, wait queue and result register.
	frwa_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.command       (command),
		.access_mode   (access_mode),
		.requester_id  (requester_id),
		.strobe        (strobe),
		.event_res     (event_res),
		.grant_id      (grant_id),
		.grant_mode    (grant_mode),
		.writer_holder (writer_holder),
		.writer_on     (writer_on),
		.reader_count  (reader_count),
		.lock_idle     (lock_idle),
		.last          (last)
	);

endmodule

[rtl/frwa_ctrl.sv]
module frwa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  frwa_pkg::stat_t  stat,
	output frwa_pkg::ctrl_t  ctrl,
	output logic             busy
);

	frwa_pkg::state_t state_q;
	frwa_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			frwa_pkg::ST_IDLE: begin
				if (start) begin
					ctrl.capture = 1'b1;
					state_d      = frwa_pkg::ST_EXEC;
				end
			end
			frwa_pkg::ST_EXEC: begin
				if (!stat.is_release) begin
					ctrl.acquire = 1'b1;
					ctrl.last    = 1'b1;
					state_d      = frwa_pkg::ST_IDLE;
				end else if (stat.rel_bad) begin
					ctrl.error = 1'b1;
					ctrl.last  = 1'b1;
					state_d    = frwa_pkg::ST_IDLE;
				end else begin
					ctrl.release_op = 1'b1;
					state_d         = frwa_pkg::ST_SCAN;
				end
			end
			frwa_pkg::ST_SCAN: begin
				// Grant the front entry if admissible, else report none; stay only if the one behind it follows.
				if (stat.head_ok) begin
					ctrl.grant = 1'b1;
					ctrl.last  = !stat.next_ok;
					if (!stat.next_ok) begin
						state_d = frwa_pkg::ST_IDLE;
					end
				end else begin
					ctrl.none = 1'b1;
					ctrl.last = 1'b1;
					state_d   = frwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frwa_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != frwa_pkg::ST_IDLE;

endmodule

[rtl/frwa_dp.sv]
`include "fifo_reader_writer_admission_macros.svh"

module frwa_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  frwa_pkg::ctrl_t                ctrl,
	output frwa_pkg::stat_t                stat,
	input  logic                           command,
	input  logic                           access_mode,
	input  logic [frwa_pkg::ID_BITS-1:0]   requester_id,
	output logic                           strobe,
	output logic [2:0]                     event_res,
	output logic [frwa_pkg::ID_BITS-1:0]   grant_id,
	output logic                           grant_mode,
	output logic [frwa_pkg::ID_BITS-1:0]   writer_holder,
	output logic                           writer_on,
	output logic [frwa_pkg::RC_W-1:0]      reader_count,
	output logic                           lock_idle,
	output logic                           last
);

	// Captured request.
	logic                         cmd_q;
	logic                         mode_q;
	logic [frwa_pkg::ID_BITS-1:0] id_q;

	// Lock state and wait queue.
	logic [frwa_pkg::ENTRY_W-1:0] queue_q [frwa_pkg::QUEUE_DEPTH];
	logic [frwa_pkg::PTR_W-1:0]   head_q, tail_q;
	logic [frwa_pkg::CNT_W-1:0]   cnt_q;
	logic [frwa_pkg::RC_W-1:0]    rc_q;
	logic                         wf_q;
	logic [frwa_pkg::ID_BITS-1:0] wid_q;

	logic [frwa_pkg::PTR_W-1:0]   head_d, tail_d, head_nx;
	logic [frwa_pkg::CNT_W-1:0]   cnt_d;
	logic [frwa_pkg::RC_W-1:0]    rc_d;
	logic                         wf_d;
	logic [frwa_pkg::ID_BITS-1:0] wid_d;
	logic                         wr_en;

	logic [frwa_pkg::ENTRY_W-1:0] head_e, next_e;
	logic                         head_mode, next_mode;
	logic [frwa_pkg::ID_BITS-1:0] head_id;

	// Next result word.
	logic                         strobe_d;
	frwa_pkg::event_t             ev_d;
	logic [frwa_pkg::ID_BITS-1:0] gid_d;
	logic                         gmode_d;
	logic                         last_d;

	// Pointer following a given one, wrapping at the queue depth.
	function automatic logic [frwa_pkg::PTR_W-1:0] ptr_inc(input logic [frwa_pkg::PTR_W-1:0] p);
		logic [frwa_pkg::PTR_W-1:0] r;
		if (p == frwa_pkg::PTR_W'(frwa_pkg::QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// Front entry and the one behind it.
	assign head_nx   = ptr_inc(head_q);
	assign head_e    = queue_q[head_q];
	assign next_e    = queue_q[head_nx];
	assign head_mode = head_e[frwa_pkg::ID_BITS];
	assign head_id   = head_e[frwa_pkg::ID_BITS-1:0];
	assign next_mode = next_e[frwa_pkg::ID_BITS];

	// Status for the controller. The look-ahead assumes the front entry is granted:
	// only a read behind a read follows, and only while the reader limit allows it.
	always_comb begin
		stat.is_release = cmd_q == frwa_pkg::CMD_RELEASE;
		stat.rel_bad    = (mode_q == frwa_pkg::MODE_READ) ? (rc_q == '0) : !wf_q;
		stat.head_ok    = (cnt_q != '0) && frwa_pkg::can_admit(head_mode, wf_q, rc_q);
		stat.next_ok    = (cnt_q > frwa_pkg::CNT_W'(1)) &&
			(head_mode == frwa_pkg::MODE_READ) && (next_mode == frwa_pkg::MODE_READ) &&
			((rc_q + 1'b1) < frwa_pkg::RC_W'(frwa_pkg::MAX_READERS));
	end

	// Next lock state and result word.
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		rc_d     = rc_q;
		wf_d     = wf_q;
		wid_d    = wid_q;
		wr_en    = 1'b0;
		strobe_d = 1'b0;
		ev_d     = frwa_pkg::EV_NONE;
		gid_d    = '0;
		gmode_d  = 1'b0;
		last_d   = ctrl.last;
		if (ctrl.acquire) begin
			strobe_d = 1'b1;
			if ((cnt_q == '0) && frwa_pkg::can_admit(mode_q, wf_q, rc_q)) begin
				ev_d    = frwa_pkg::EV_GRANT;
				gid_d   = id_q;
				gmode_d = mode_q;
				if (mode_q == frwa_pkg::MODE_READ) begin
					rc_d = rc_q + 1'b1;
				end else begin
					wf_d  = 1'b1;
					wid_d = id_q;
				end
			end else if (cnt_q == frwa_pkg::CNT_W'(frwa_pkg::QUEUE_DEPTH)) begin
				ev_d = frwa_pkg::EV_FULL;
			end else begin
				ev_d   = frwa_pkg::EV_QUEUED;
				wr_en  = 1'b1;
				tail_d = ptr_inc(tail_q);
				cnt_d  = cnt_q + 1'b1;
			end
		end
		if (ctrl.error) begin
			strobe_d = 1'b1;
			ev_d     = frwa_pkg::EV_RELERR;
		end
		if (ctrl.release_op) begin
			if (mode_q == frwa_pkg::MODE_READ) begin
				rc_d = rc_q - 1'b1;
			end else begin
				wf_d  = 1'b0;
				wid_d = '0;
			end
		end
		if (ctrl.grant) begin
			strobe_d = 1'b1;
			ev_d     = frwa_pkg::EV_GRANT;
			gid_d    = head_id;
			gmode_d  = head_mode;
			head_d   = head_nx;
			cnt_d    = cnt_q - 1'b1;
			if (head_mode == frwa_pkg::MODE_READ) begin
				rc_d = rc_q + 1'b1;
			end else begin
				wf_d  = 1'b1;
				wid_d = head_id;
			end
		end
		if (ctrl.none) begin
			strobe_d = 1'b1;
			ev_d     = frwa_pkg::EV_NONE;
		end
	end

	// Request capture and queue storage.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q  <= command;
			mode_q <= access_mode;
			id_q   <= requester_id;
		end
		if (wr_en) begin
			queue_q[tail_q] <= {mode_q, id_q};
		end
	end

	// Lock state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			rc_q   <= '0;
			wf_q   <= 1'b0;
			wid_q  <= '0;
			strobe <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
			rc_q   <= rc_d;
			wf_q   <= wf_d;
			wid_q  <= wid_d;
			strobe <= strobe_d;
		end
	end

	// Result word, showing the state after the reported step.
	always_ff @(posedge clk) begin
		if (strobe_d) begin
			event_res     <= ev_d;
			grant_id      <= gid_d;
			grant_mode    <= gmode_d;
			writer_holder <= wf_d ? wid_d : '0;
			writer_on     <= wf_d;
			reader_count  <= rc_d;
			lock_idle     <= (cnt_d == '0) && (rc_d == '0) && !wf_d;
			last          <= last_d;
		end
	end

	`FRWA_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1,
		cnt_q <= frwa_pkg::CNT_W'(frwa_pkg::QUEUE_DEPTH), "queue count beyond depth")
	`FRWA_ASSERT_IMP(a_excl, clk, arst_n, strobe && writer_on,
		reader_count == '0, "writer reported together with readers")
	`FRWA_ASSERT_NXT(a_grant_out, clk, arst_n, ctrl.grant,
		strobe && (event_res == frwa_pkg::EV_GRANT), "grant without a grant result")

endmodule
